### design/cspn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspn_pkg
// Shared widths, latencies, the configuration struct and clamp helpers for
// the centripetal spline node smoother.
// ----------------------------------------------------------------------------
package cspn_pkg;

	localparam int CRD_W   = 16;                 // Q3.12 coordinate
	localparam int KNOT_W  = 48;                 // packed x y z
	localparam int KW      = 17;                 // knot parameter t1..t3
	localparam int TW      = 19;                 // node parameter t
	localparam int SQ_W    = 36;                 // squared distance, Q.24
	localparam int DN_W    = SQ_W / 2;           // distance, Q.12
	localparam int STEP_W  = 15;                 // one knot parameter step
	localparam int PW      = 37;                 // pyramid point, signed
	localparam int FQ_W    = 20;                 // quotient bits, node parameter
	localparam int BQ_W    = 36;                 // quotient bits, pyramid blend
	localparam int BL_LAT  = BQ_W + 5;           // cycles through one blend
	localparam int FRONT_LAT = 2 + SQ_W / 2 + 2 + (FQ_W + 1) + 1;
	localparam int TOTAL_LAT = FRONT_LAT + 3 * BL_LAT;

	localparam logic [TW-1:0] TIME_MAX = 19'd524287;
	localparam logic signed [PW:0] PT_HI = 38'sd34359738368;
	localparam logic signed [PW:0] PT_LO = -38'sd34359738368;

	typedef logic [KNOT_W-1:0] cspn_knot_t;

	typedef struct packed {
		cspn_knot_t [3:0]    knot;
		logic [STEP_W-1:0]   step1;
		logic [DN_W-1:0]     s1;
		logic [KW-1:0]       t1;
		logic [KW-1:0]       t2;
		logic [KW-1:0]       t3;
		logic                degen;
		logic                busy;
	} cspn_cfg_t;

	function automatic logic signed [PW-1:0] clamp_pt(input logic signed [PW:0] v);
		logic signed [PW-1:0] r;
		if (v > PT_HI) begin
			r = PW'(PT_HI);
		end else if (v < PT_LO) begin
			r = PW'(PT_LO);
		end else begin
			r = PW'(v);
		end
		return r;
	endfunction

	function automatic logic [CRD_W-1:0] sat16(input logic signed [PW-1:0] v);
		logic [CRD_W-1:0] r;
		if (v > 37'sd32767) begin
			r = 16'h7fff;
		end else if (v < -37'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[CRD_W-1:0];
		end
		return r;
	endfunction

endpackage

### design/cspn_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspn_delay
// Enabled shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module cspn_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] d_s [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) d_s[i] <= '0;
		end else if (en) begin
			d_s[0] <= d;
			for (int i = 1; i < D; i++) d_s[i] <= d_s[i-1];
		end
	end

	assign q = d_s[D-1];

endmodule

### design/cspn_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspn_sqrt_pipe
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module cspn_sqrt_pipe #(
	parameter int IW = 36
) (
	input  logic            clk,
	input  logic            en,
	input  logic [IW-1:0]   v,
	output logic [IW/2-1:0] root
);

	localparam int S  = IW / 2;
	localparam int RW = IW + 1;

	logic [RW-1:0] rem_s  [S];
	logic [RW-1:0] root_s [S];

	genvar k;
	for (k = 0; k < S; k++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (IW - 2 - 2 * k);
		logic [RW-1:0] vi, ri, trial;
		logic          ge;
		if (k == 0) begin : g_first
			assign vi = RW'(v);
			assign ri = '0;
		end else begin : g_next
			assign vi = rem_s[k-1];
			assign ri = root_s[k-1];
		end
		assign trial = ri + BIT;
		assign ge    = vi >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? vi - trial : vi;
				root_s[k] <= ge ? (ri >> 1) + BIT : ri >> 1;
			end
		end
	end

	assign root = root_s[S-1][S-1:0];

endmodule

### design/cspn_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspn_div_pipe
// Unsigned restoring divider, one quotient bit per stage. The caller must
// hold the divisor steady while items are in flight; the block does not
// enforce it. Quotients that do not fit in QW bits come out as all ones.
// ----------------------------------------------------------------------------
module cspn_div_pipe #(
	parameter int NW = 34,
	parameter int DW = 18,
	parameter int QW = 20
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [NW-1:0] rem_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic          ovf_s [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			ovf_s[0] <= CW'(num) >= (CW'(den) << QW);
		end
	end

	genvar k;
	for (k = 1; k <= QW; k++) begin : g_stage
		localparam int SH = QW - k;
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = CW'(den) << SH;
		assign ge  = CW'(rem_s[k-1]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? NW'(CW'(rem_s[k-1]) - dsh) : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (QW'(ge) << SH);
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = ovf_s[QW] ? '1 : quo_s[QW];

endmodule

### design/cspn_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspn_blend
// One pyramid interpolant: round(((th - t) * x + (t - tl) * y) / (th - tl)),
// ties away from zero, clamped to the intermediate point range.
// ----------------------------------------------------------------------------
module cspn_blend
	import cspn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [TW-1:0]        t,
	input  logic [KW-1:0]        tl,
	input  logic [KW-1:0]        th,
	input  logic signed [PW-1:0] x,
	input  logic signed [PW-1:0] y,
	output logic signed [PW-1:0] v
);

	localparam int MW  = TW + 2;
	localparam int LW  = 18;
	localparam int HW  = PW - LW;
	localparam int PPW = MW + HW;
	localparam int NMW = 58;

	logic signed [MW-1:0]  m1, m2;
	logic signed [HW-1:0]  xh, xl, yh, yl;
	logic signed [PPW-1:0] p1h_s1, p1l_s1, p2h_s1, p2l_s1;
	logic signed [NMW-1:0] num_s2;
	logic [NMW-1:0]        mag;
	logic [KW-1:0]         den;
	logic [NMW-1:0]        a_s3;
	logic                  neg_s3;
	logic [BQ_W-1:0]       quo;
	logic                  neg_d;
	logic signed [PW:0]    qx, qv;
	logic signed [PW-1:0]  v_s4;

	assign m1  = $signed(MW'(th)) - $signed(MW'(t));
	assign m2  = $signed(MW'(t)) - $signed(MW'(tl));
	assign xh  = x[PW-1:LW];
	assign xl  = $signed({1'b0, x[LW-1:0]});
	assign yh  = y[PW-1:LW];
	assign yl  = $signed({1'b0, y[LW-1:0]});
	assign den = KW'(th - tl);

	always_ff @(posedge clk) begin
		if (en) begin
			p1h_s1 <= m1 * xh;
			p1l_s1 <= m1 * xl;
			p2h_s1 <= m2 * yh;
			p2l_s1 <= m2 * yl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= (NMW'(p1h_s1) <<< LW) + NMW'(p1l_s1)
			        + (NMW'(p2h_s1) <<< LW) + NMW'(p2l_s1);
		end
	end

	assign mag = num_s2[NMW-1] ? NMW'(-num_s2) : NMW'(num_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= mag + NMW'(den >> 1);
			neg_s3 <= num_s2[NMW-1];
		end
	end

	cspn_div_pipe #(.NW(NMW), .DW(KW), .QW(BQ_W)) u_div (
		.clk (clk),
		.en  (en),
		.num (a_s3),
		.den (den),
		.quo (quo)
	);

	cspn_delay #(.W(1), .D(BQ_W + 1)) u_sign (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (neg_s3),
		.q      (neg_d)
	);

	assign qx = $signed({2'b00, quo});
	assign qv = neg_d ? -qx : qx;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= clamp_pt(qv);
		end
	end

	assign v = v_s4;

endmodule

### design/cspn_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspn_cfg
// Knot registers and the sequencer that derives knot parameters from them
// with one shared bit-serial square root.
// ----------------------------------------------------------------------------
module cspn_cfg
	import cspn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [KNOT_W-1:0] cfg_data,
	output cspn_cfg_t         cfg
);

	localparam int RW = 61;
	localparam logic [RW-1:0] SBIT0 = RW'(1) << 58;

	typedef enum logic [2:0] {ST_IDLE, ST_SQ, ST_RT1, ST_RT2, ST_RS1} state_t;

	state_t              state_q;
	cspn_knot_t          knot_q [4];
	logic [1:0]          k_q, c_q;
	logic [SQ_W-1:0]     acc_q, sq1_q;
	logic [RW-1:0]       sv_q, sr_q, sbit_q;
	logic [STEP_W-1:0]   step_q [3];
	logic [DN_W-1:0]     s1_q;
	logic                degen_q, degacc_q;

	logic [1:0]          k_nx;
	logic [5:0]          off;
	logic signed [16:0]  da, db, dd;
	logic signed [33:0]  dsq;
	logic [SQ_W-1:0]     acc_nx;
	logic [RW-1:0]       trial, sv_nx, sr_nx;
	logic                ge, last;

	assign k_nx   = 2'(k_q + 2'd1);
	assign off    = {c_q, 4'b0000};
	assign da     = 17'($signed(knot_q[k_nx][off +: CRD_W]));
	assign db     = 17'($signed(knot_q[k_q][off +: CRD_W]));
	assign dd     = da - db;
	assign dsq    = dd * dd;
	assign acc_nx = acc_q + SQ_W'(dsq[33:0]);

	assign trial = sr_q + sbit_q;
	assign ge    = sv_q >= trial;
	assign sv_nx = ge ? sv_q - trial : sv_q;
	assign sr_nx = ge ? (sr_q >> 1) + sbit_q : sr_q >> 1;
	assign last  = sbit_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			for (int i = 0; i < 4; i++) knot_q[i] <= '0;
			for (int i = 0; i < 3; i++) step_q[i] <= '0;
			k_q      <= '0;
			c_q      <= '0;
			acc_q    <= '0;
			sq1_q    <= '0;
			sv_q     <= '0;
			sr_q     <= '0;
			sbit_q   <= '0;
			s1_q     <= '0;
			degen_q  <= 1'b1;
			degacc_q <= 1'b0;
		end else if (cfg_we) begin
			// restart the derivation on every write
			knot_q[cfg_index] <= cfg_data;
			state_q  <= ST_SQ;
			k_q      <= '0;
			c_q      <= '0;
			acc_q    <= '0;
			degacc_q <= 1'b0;
		end else begin
			case (state_q)
				ST_SQ: begin
					if (c_q == 2'd2) begin
						acc_q   <= '0;
						c_q     <= '0;
						sv_q    <= RW'(acc_nx) << 24;
						sr_q    <= '0;
						sbit_q  <= SBIT0;
						state_q <= ST_RT1;
						if (acc_nx == '0) degacc_q <= 1'b1;
						if (k_q == 2'd1) sq1_q <= acc_nx;
					end else begin
						acc_q <= acc_nx;
						c_q   <= 2'(c_q + 2'd1);
					end
				end
				ST_RT1: begin
					if (last) begin
						sv_q    <= sr_nx;
						sr_q    <= '0;
						sbit_q  <= SBIT0;
						state_q <= ST_RT2;
					end else begin
						sv_q   <= sv_nx;
						sr_q   <= sr_nx;
						sbit_q <= sbit_q >> 2;
					end
				end
				ST_RT2: begin
					if (last) begin
						step_q[k_q] <= sr_nx[STEP_W-1:0];
						if (k_q == 2'd2) begin
							sv_q    <= RW'(sq1_q);
							sr_q    <= '0;
							sbit_q  <= SBIT0;
							state_q <= ST_RS1;
						end else begin
							k_q     <= k_nx;
							state_q <= ST_SQ;
						end
					end else begin
						sv_q   <= sv_nx;
						sr_q   <= sr_nx;
						sbit_q <= sbit_q >> 2;
					end
				end
				ST_RS1: begin
					if (last) begin
						s1_q    <= sr_nx[DN_W-1:0];
						degen_q <= degacc_q;
						state_q <= ST_IDLE;
					end else begin
						sv_q   <= sv_nx;
						sr_q   <= sr_nx;
						sbit_q <= sbit_q >> 2;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) cfg.knot[i] = knot_q[i];
		cfg.step1 = step_q[1];
		cfg.s1    = s1_q;
		cfg.t1    = KW'(step_q[0]);
		cfg.t2    = KW'(step_q[0]) + KW'(step_q[1]);
		cfg.t3    = KW'(step_q[0]) + KW'(step_q[1]) + KW'(step_q[2]);
		cfg.degen = degen_q;
		cfg.busy  = state_q != ST_IDLE;
	end

endmodule

### design/centripetal_spline_node_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centripetal_spline_node_smoother_core
// Places each node on the p1-p2 segment of a centripetal Catmull-Rom spline
// and returns the point re-evaluated through the Barry-Goldman pyramid.
// ----------------------------------------------------------------------------
// Takes one node per cycle while in_ready is high and returns each smoothed
// node from a fully pipelined datapath: a square-root pipe, a bit-per-stage
// divider for the node parameter and three levels of blend units, each with
// its own bit-per-stage divider. A final output register and a skid stage
// keep nodes flowing while a result waits. Every knot write starts a recompute
// of the knot parameters on one shared bit-serial square root, during which
// in_ready is low; write all knots before streaming nodes. If two consecutive
// knots coincide, nodes pass unchanged with degenerate set.
// ----------------------------------------------------------------------------
module centripetal_spline_node_smoother_core
	import cspn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [KNOT_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CRD_W-1:0]  node_x,
	input  logic [CRD_W-1:0]  node_y,
	input  logic [CRD_W-1:0]  node_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CRD_W-1:0]  out_x,
	output logic [CRD_W-1:0]  out_y,
	output logic [CRD_W-1:0]  out_z,
	output logic              degenerate
);

	localparam int OW = 3 * CRD_W + 1;

	cspn_cfg_t cfg;

	logic                en, take;
	logic [CRD_W-1:0]    node [3];
	logic signed [16:0]  dx [3];
	logic signed [33:0]  dq [3];
	logic [33:0]         dsq_s1 [3];
	logic [SQ_W-1:0]     sqd_s2;
	logic [DN_W-1:0]     dn;
	logic [32:0]         prod_s3;
	logic [33:0]         num_s4;
	logic [FQ_W-1:0]     fq;
	logic [20:0]         tsum;
	logic [TW-1:0]       t_s5, t_l2, t_l3;
	logic signed [PW-1:0] kp [4][3];
	logic signed [PW-1:0] a1 [3], a2 [3], a3 [3], b1 [3], b2 [3], r [3];
	logic                last_v;
	logic [3*CRD_W-1:0]  node_d;
	logic [OW-1:0]       res, out_q, skid_q;
	logic                out_v_q, skid_v_q, pop;

	cspn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// hold the whole pipeline while the skid stage is full
	assign en       = !skid_v_q;
	assign in_ready = en && !cfg.busy;
	assign take     = in_valid && in_ready;

	assign node[0] = node_x;
	assign node[1] = node_y;
	assign node[2] = node_z;

	for (genvar c = 0; c < 3; c++) begin : g_dist
		assign dx[c] = 17'($signed(node[c])) - 17'($signed(cfg.knot[1][c*CRD_W +: CRD_W]));
		assign dq[c] = dx[c] * dx[c];
		always_ff @(posedge clk) begin
			if (en) dsq_s1[c] <= dq[c][33:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) sqd_s2 <= SQ_W'(dsq_s1[0]) + SQ_W'(dsq_s1[1]) + SQ_W'(dsq_s1[2]);
	end

	cspn_sqrt_pipe #(.IW(SQ_W)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.v    (sqd_s2),
		.root (dn)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= 33'(cfg.step1) * 33'(dn);
			num_s4  <= 34'(prod_s3) + 34'(cfg.s1 >> 1);
		end
	end

	cspn_div_pipe #(.NW(34), .DW(DN_W), .QW(FQ_W)) u_div (
		.clk (clk),
		.en  (en),
		.num (num_s4),
		.den (cfg.s1),
		.quo (fq)
	);

	assign tsum = 21'(cfg.t1) + 21'(fq);

	always_ff @(posedge clk) begin
		if (en) t_s5 <= (tsum > 21'(TIME_MAX)) ? TIME_MAX : tsum[TW-1:0];
	end

	cspn_delay #(.W(TW), .D(BL_LAT)) u_t2 (
		.clk (clk), .arst_n (arst_n), .en (en), .d (t_s5), .q (t_l2)
	);

	cspn_delay #(.W(TW), .D(BL_LAT)) u_t3 (
		.clk (clk), .arst_n (arst_n), .en (en), .d (t_l2), .q (t_l3)
	);

	for (genvar c = 0; c < 3; c++) begin : g_crd
		for (genvar k = 0; k < 4; k++) begin : g_knot
			assign kp[k][c] = PW'($signed(cfg.knot[k][c*CRD_W +: CRD_W]));
		end

		cspn_blend u_a1 (.clk (clk), .arst_n (arst_n), .en (en), .t (t_s5),
			.tl ('0), .th (cfg.t1), .x (kp[0][c]), .y (kp[1][c]), .v (a1[c]));
		cspn_blend u_a2 (.clk (clk), .arst_n (arst_n), .en (en), .t (t_s5),
			.tl (cfg.t1), .th (cfg.t2), .x (kp[1][c]), .y (kp[2][c]), .v (a2[c]));
		cspn_blend u_a3 (.clk (clk), .arst_n (arst_n), .en (en), .t (t_s5),
			.tl (cfg.t2), .th (cfg.t3), .x (kp[2][c]), .y (kp[3][c]), .v (a3[c]));
		cspn_blend u_b1 (.clk (clk), .arst_n (arst_n), .en (en), .t (t_l2),
			.tl ('0), .th (cfg.t2), .x (a1[c]), .y (a2[c]), .v (b1[c]));
		cspn_blend u_b2 (.clk (clk), .arst_n (arst_n), .en (en), .t (t_l2),
			.tl (cfg.t1), .th (cfg.t3), .x (a2[c]), .y (a3[c]), .v (b2[c]));
		cspn_blend u_c  (.clk (clk), .arst_n (arst_n), .en (en), .t (t_l3),
			.tl (cfg.t1), .th (cfg.t2), .x (b1[c]), .y (b2[c]), .v (r[c]));
	end

	cspn_delay #(.W(1), .D(TOTAL_LAT)) u_vld (
		.clk (clk), .arst_n (arst_n), .en (en), .d (take), .q (last_v)
	);

	cspn_delay #(.W(3 * CRD_W), .D(TOTAL_LAT)) u_node (
		.clk (clk), .arst_n (arst_n), .en (en), .d ({node_z, node_y, node_x}),
		.q (node_d)
	);

	// coincident knots: pass the node through untouched
	assign res = cfg.degen ? {1'b1, node_d}
	                       : {1'b0, sat16(r[2]), sat16(r[1]), sat16(r[0])};

	assign pop = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en && last_v) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q && pop) begin
			skid_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_v) begin
			if (!out_v_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (skid_v_q && pop) begin
			out_q <= skid_q;
		end
	end

	assign out_valid  = out_v_q;
	assign out_x      = out_q[CRD_W-1:0];
	assign out_y      = out_q[2*CRD_W-1:CRD_W];
	assign out_z      = out_q[3*CRD_W-1:2*CRD_W];
	assign degenerate = out_q[3*CRD_W];

endmodule
